[sv/id_free_list_allocator_core_assert.svh]
// Assertion macros for the ID free-list allocator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ID_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define ID_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define IDFL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IDFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/idfl_pkg.sv]
// Shared constants and types for the ID free-list allocator.
// No dependencies; imported by the allocator core module.
package idfl_pkg;

    localparam int CAPACITY     = 256;
    localparam int PAYLOAD_BITS = 32;
    localparam int ID_BITS      = 8;
    localparam int ADDR_BITS    = $clog2(CAPACITY);
    localparam int PTR_BITS     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        K_ACQUIRE = 2'd0,
        K_RELEASE = 2'd1,
        K_SET     = 2'd2,
        K_GET     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

[sv/idfl_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies; used for the link store and the payload store.
module idfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/id_free_list_allocator_core.sv]
// Acquire from fresh IDs, release, set and rejected items give their result in the cycle
// after the transfer; acquire from the free list and get first wait in S_READ for the
// registered read of the link or payload RAM, then register their result.
// A new item is taken only in S_IDLE and only while the result side keeps up.
// Reset (synchronous, active low) empties the free list and the pool; RAMs are not cleared.
module id_free_list_allocator_core
    import idfl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_kind,
    input  logic [ID_BITS-1:0]      i_slot_id,
    input  logic [PAYLOAD_BITS-1:0] i_payload_in,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic [ID_BITS-1:0]      o_granted_id,
    output logic [PAYLOAD_BITS-1:0] o_payload_out,
    output logic [PTR_BITS-1:0]     o_pool_size
);

`include "id_free_list_allocator_core_assert.svh"

    t_state                  r_state, n_state;
    logic [PTR_BITS-1:0]     r_free_head, n_free_head;
    logic [PTR_BITS-1:0]     r_fresh_next, n_fresh_next;
    logic [PTR_BITS-1:0]     r_pool_count, n_pool_count;
    logic                    r_pop, n_pop;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic [ID_BITS-1:0]      r_granted, n_granted;
    logic [PAYLOAD_BITS-1:0] r_payload, n_payload;
    logic [PTR_BITS-1:0]     r_pool_out, n_pool_out;

    logic                    w_in_xfer;
    logic                    w_out_free;
    logic                    w_list_empty;
    logic                    w_in_range;
    logic [PTR_BITS:0]       w_pool_dbl;
    logic [PTR_BITS-1:0]     w_pool_grown;

    logic                    link_en, link_we;
    logic [ADDR_BITS-1:0]    link_addr;
    logic [PTR_BITS-1:0]     link_rdata;
    logic                    pay_en, pay_we;
    logic [PAYLOAD_BITS-1:0] pay_rdata;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall   = (r_state != S_IDLE) || !w_out_free;
    assign w_in_xfer    = i_in_valid && !o_in_stall;
    assign w_list_empty = (r_free_head >= PTR_BITS'(CAPACITY));
    assign w_in_range   = ({{(PTR_BITS - ID_BITS){1'b0}}, i_slot_id} < r_pool_count);

    // Pool grows 0 -> 1 -> 2 -> 4 ... capped at capacity
    assign w_pool_dbl = (r_pool_count == '0) ? (PTR_BITS + 1)'(1)
                                             : {r_pool_count, 1'b0};
    always_comb begin
        w_pool_grown = r_pool_count;
        if (r_fresh_next >= r_pool_count && r_pool_count < PTR_BITS'(CAPACITY)) begin
            if (w_pool_dbl > (PTR_BITS + 1)'(CAPACITY)) begin
                w_pool_grown = PTR_BITS'(CAPACITY);
            end else begin
                w_pool_grown = w_pool_dbl[PTR_BITS-1:0];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_fresh_next = r_fresh_next;
        n_pool_count = r_pool_count;
        n_pop        = r_pop;
        n_out_valid  = r_out_valid && i_out_stall;
        n_status     = r_status;
        n_granted    = r_granted;
        n_payload    = r_payload;
        n_pool_out   = r_pool_out;
        link_en      = 1'b0;
        link_we      = 1'b0;
        link_addr    = r_free_head[ADDR_BITS-1:0];
        pay_en       = 1'b0;
        pay_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_status   = ST_OK;
                    n_granted  = '0;
                    n_payload  = '0;
                    n_pool_out = r_pool_count;
                    if (t_kind'(i_kind) == K_ACQUIRE) begin
                        if (!w_list_empty) begin
                            link_en = 1'b1;
                            n_pop   = 1'b1;
                            n_state = S_READ;
                        end else begin
                            n_pool_count = w_pool_grown;
                            n_pool_out   = w_pool_grown;
                            n_out_valid  = 1'b1;
                            if (r_fresh_next < w_pool_grown) begin
                                n_granted    = r_fresh_next[ID_BITS-1:0];
                                n_fresh_next = r_fresh_next + PTR_BITS'(1);
                            end else begin
                                n_status = ST_EMPTY;
                            end
                        end
                    end else if (!w_in_range) begin
                        n_status    = ST_RANGE;
                        n_out_valid = 1'b1;
                    end else begin
                        case (t_kind'(i_kind))
                            K_RELEASE: begin
                                link_en     = 1'b1;
                                link_we     = 1'b1;
                                link_addr   = i_slot_id[ADDR_BITS-1:0];
                                n_free_head = {{(PTR_BITS - ID_BITS){1'b0}}, i_slot_id};
                                n_out_valid = 1'b1;
                            end
                            K_SET: begin
                                pay_en      = 1'b1;
                                pay_we      = 1'b1;
                                n_out_valid = 1'b1;
                            end
                            K_GET: begin
                                pay_en  = 1'b1;
                                n_pop   = 1'b0;
                                n_state = S_READ;
                            end
                            default: begin
                                n_out_valid = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_pop) begin
                        n_granted = r_free_head[ID_BITS-1:0];
                        if (link_rdata > PTR_BITS'(CAPACITY)) begin
                            n_free_head = PTR_BITS'(CAPACITY);
                        end else begin
                            n_free_head = link_rdata;
                        end
                    end else begin
                        n_payload = pay_rdata;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head  <= PTR_BITS'(CAPACITY);
            r_fresh_next <= '0;
            r_pool_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_free_head  <= n_free_head;
            r_fresh_next <= n_fresh_next;
            r_pool_count <= n_pool_count;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop      <= n_pop;
        r_status   <= n_status;
        r_granted  <= n_granted;
        r_payload  <= n_payload;
        r_pool_out <= n_pool_out;
    end

    idfl_ram #(
        .WIDTH (PTR_BITS),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_en    (link_en),
        .i_we    (link_we),
        .i_addr  (link_addr),
        .i_wdata (r_free_head),
        .o_rdata (link_rdata)
    );

    idfl_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (CAPACITY)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_en    (pay_en),
        .i_we    (pay_we),
        .i_addr  (i_slot_id[ADDR_BITS-1:0]),
        .i_wdata (i_payload_in),
        .o_rdata (pay_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_granted_id  = r_granted;
    assign o_payload_out = r_payload;
    assign o_pool_size   = r_pool_out;

    `IDFL_ASSERT_NOW(a_pool_cap, i_clk, i_rst_n, 1'b1, r_pool_count <= PTR_BITS'(CAPACITY), "pool above capacity")
    `IDFL_ASSERT_NOW(a_fresh_in_pool, i_clk, i_rst_n, 1'b1, r_fresh_next <= r_pool_count, "fresh ID beyond pool")
    `IDFL_ASSERT_NOW(a_head_bound, i_clk, i_rst_n, 1'b1, r_free_head <= PTR_BITS'(CAPACITY), "free head out of bounds")
    `IDFL_ASSERT_NOW(a_no_xfer_in_read, i_clk, i_rst_n, r_state == S_READ, o_in_stall, "transfer taken during RAM read")
    `IDFL_ASSERT_NEXT(a_pop_reads, i_clk, i_rst_n, w_in_xfer && (t_kind'(i_kind) == K_ACQUIRE) && !w_list_empty, (r_state == S_READ) && r_pop && !r_out_valid, "free-list pop did not wait for link read")

endmodule
